[rtl/spws_pkg.sv]
`default_nettype none
package spws_pkg;

  localparam int unsigned RingDepthDef  = 1024;
  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned MinWindowDef  = 10;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_TICK_US     = 2'd1,
    CFG_VREF        = 2'd2,
    CFG_FULL_SCALE  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_SAMPLE  = 1'b0,
    REQ_CAPTURE = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WIN_MUL,
    ST_WIN_DIV,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_MUL_DC,
    ST_MUL_VPP,
    ST_DIV_DC,
    ST_DIV_VPP,
    ST_DIV_FREQ,
    ST_SHOW
  } bk_state_e;

  // One queued item handed from the front to the back.
  typedef struct packed {
    logic        is_capture;
    logic [15:0] data;
  } item_t;

  localparam logic [12:0] MvSat = 13'd8191;

endpackage
`default_nettype wire

[rtl/spws_ram.sv]
`default_nettype none
module spws_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/spws_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module spws_divider #(
  parameter int unsigned Width = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  done_o,
  output logic      [Width-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [Width:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[Width-1]} - {1'b0, dvs_q};
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

[rtl/spws_front.sv]
`default_nettype none
// Accepts transactions into a small queue that the back end drains.
module spws_front #(
  parameter int unsigned QDepth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire spws_pkg::item_t     item_i,
  output logic                     q_valid_o,
  input  wire logic                q_pop_i,
  output spws_pkg::item_t          q_item_o
);
  localparam int unsigned PtrW = $clog2(QDepth);

  spws_pkg::item_t  slot_q [QDepth];
  logic [PtrW-1:0]  rd_q, wr_q;
  logic [PtrW:0]    cnt_q;
  logic             push, pop;

  assign in_stall_o = (cnt_q == (PtrW+1)'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= item_i;
  end
endmodule
`default_nettype wire

[rtl/spws_back.sv]
`default_nettype none
// Executes queued items: ring writes, period update and window statistics.
module spws_back #(
  parameter int unsigned RingDepth  = 1024,
  parameter int unsigned SampleBits = 12,
  parameter int unsigned MinWindow  = 10
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  output logic                 q_pop_o,
  input  wire spws_pkg::item_t q_item_i,
  input  wire logic [19:0]     sample_rate_hz_i,
  input  wire logic [15:0]     tick_us_i,
  input  wire logic [12:0]     vref_mv_i,
  input  wire logic [15:0]     full_scale_code_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 period_known_o,
  output logic [31:0]          period_us_o,
  output logic [26:0]          frequency_centihz_o,
  output logic [10:0]          window_len_o,
  output logic [12:0]          dc_offset_mv_o,
  output logic [12:0]          vpp_mv_o,
  output logic [11:0]          amplitude_mv_o
);
  localparam int unsigned AW   = $clog2(RingDepth);
  localparam int unsigned WinW = AW + 1;
  localparam int unsigned SumW = SampleBits + AW;
  localparam int unsigned DW   = 56;

  // The window is period * rate / 2000000. Dividing by 128 first leaves a division
  // by 15625, done by multiplying with ceil(2^44 / 15625), which is exact for any
  // dividend below 2^30. Products at or above the cap always clamp to the ring depth.
  localparam logic [DW-1:0] WinCapProd = DW'((64'(RingDepth) + 64'd1) * 64'd2000000);
  localparam logic [30:0]   WinRecip   = 31'd1125899907;

  spws_pkg::bk_state_e state_q, state_d;

  logic [AW-1:0]         widx_q, raddr_q;
  logic [AW:0]           clr_q;
  logic [15:0]           prev_q;
  logic                  first_q;
  logic [31:0]           period_q;
  logic [WinW-1:0]       win_q, cnt_q;
  logic [SumW-1:0]       sum_q;
  logic [SampleBits-1:0] max_q, min_q, rdata;
  logic [31:0]           prod_q;
  logic [DW-1:0]         dvd_q, dvs_q, quo;
  logic                  div_start_q, div_done;
  logic [12:0]           dc_q, vpp_q;
  logic [26:0]           freq_q;
  logic                  rd_valid_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SampleBits-1:0] ram_wdata;

  logic                  is_cap, is_smp;
  logic [15:0]           delta;
  logic [15:0]           fs;
  logic [16:0]           win_quo;
  logic [DW-1:0]         win_raw;

  assign is_cap = q_valid_i && (state_q == spws_pkg::ST_IDLE) &&
                  (q_item_i.is_capture == spws_pkg::REQ_CAPTURE);
  assign is_smp = q_valid_i && (state_q == spws_pkg::ST_IDLE) &&
                  (q_item_i.is_capture == spws_pkg::REQ_SAMPLE);
  assign q_pop_o = is_cap || is_smp;
  assign delta   = q_item_i.data - prev_q;
  assign fs      = (full_scale_code_i == '0) ? 16'd1 : full_scale_code_i;

  assign ram_we    = is_smp || (state_q == spws_pkg::ST_CLEAR);
  assign ram_waddr = (state_q == spws_pkg::ST_CLEAR) ? clr_q[AW-1:0] : widx_q;
  assign ram_wdata = (state_q == spws_pkg::ST_CLEAR) ? '0 :
                     q_item_i.data[SampleBits-1:0];

  spws_ram #(.Width(SampleBits), .Depth(RingDepth)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  spws_divider #(.Width(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign win_quo = 17'((61'(dvd_q[36:7]) * 61'(WinRecip)) >> 44);
  assign win_raw = (dvd_q >= WinCapProd) ? DW'(RingDepth + 1) : DW'(win_quo);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spws_pkg::ST_CLEAR:     if (clr_q == (AW+1)'(RingDepth - 1)) state_d = spws_pkg::ST_IDLE;
      spws_pkg::ST_IDLE:      if (is_cap) state_d = spws_pkg::ST_WIN_MUL;
      spws_pkg::ST_WIN_MUL:   state_d = spws_pkg::ST_WIN_DIV;
      spws_pkg::ST_WIN_DIV:   state_d = spws_pkg::ST_SCAN;
      spws_pkg::ST_SCAN:      if (cnt_q == win_q) state_d = spws_pkg::ST_SCAN_TAIL;
      spws_pkg::ST_SCAN_TAIL: state_d = spws_pkg::ST_MUL_DC;
      spws_pkg::ST_MUL_DC:    state_d = spws_pkg::ST_DIV_DC;
      spws_pkg::ST_DIV_DC:    if (div_done) state_d = spws_pkg::ST_MUL_VPP;
      spws_pkg::ST_MUL_VPP:   state_d = spws_pkg::ST_DIV_VPP;
      spws_pkg::ST_DIV_VPP:   if (div_done) state_d = spws_pkg::ST_DIV_FREQ;
      spws_pkg::ST_DIV_FREQ:  if (div_done || period_q == '0) state_d = spws_pkg::ST_SHOW;
      spws_pkg::ST_SHOW:      if (!out_stall_i) state_d = spws_pkg::ST_IDLE;
      default:                state_d = spws_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    out_valid_o         = (state_q == spws_pkg::ST_SHOW);
    period_known_o      = (period_q != '0);
    period_us_o         = period_q;
    frequency_centihz_o = freq_q;
    window_len_o        = 11'(win_q);
    dc_offset_mv_o      = dc_q;
    vpp_mv_o            = vpp_q;
    amplitude_mv_o      = vpp_q[12:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spws_pkg::ST_CLEAR;
      clr_q       <= '0;
      widx_q      <= '0;
      prev_q      <= '0;
      first_q     <= 1'b1;
      period_q    <= '0;
      div_start_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= (state_q == spws_pkg::ST_MUL_DC) ||
                     (state_q == spws_pkg::ST_MUL_VPP) ||
                     ((state_q == spws_pkg::ST_DIV_VPP) && div_done && (period_q != '0));
      rd_valid_q  <= (state_q == spws_pkg::ST_SCAN) && (cnt_q != '0);
      if (state_q == spws_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (is_smp) widx_q <= widx_q + 1'b1;
      if (is_cap) begin
        prev_q  <= q_item_i.data;
        first_q <= 1'b0;
        if (!first_q && delta != '0) period_q <= 32'(delta * tick_us_i);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      spws_pkg::ST_IDLE: begin
        if (is_cap) begin
          prod_q <= (first_q || delta == '0) ? period_q : 32'(delta * tick_us_i);
        end
      end
      spws_pkg::ST_WIN_MUL: begin
        dvd_q <= DW'(prod_q * sample_rate_hz_i);
      end
      spws_pkg::ST_WIN_DIV: begin
        if (win_raw < DW'(MinWindow)) win_q <= WinW'(MinWindow > RingDepth ?
                                                 RingDepth : MinWindow);
        else if (win_raw > DW'(RingDepth)) win_q <= WinW'(RingDepth);
        else win_q <= WinW'(win_raw);
        cnt_q   <= '0;
        sum_q   <= '0;
        max_q   <= '0;
        min_q   <= '1;
        raddr_q <= '0;
      end
      spws_pkg::ST_SCAN: begin
        // The first scan cycle only sets the start address; reads follow one a cycle.
        if (cnt_q == '0) raddr_q <= widx_q - AW'(win_q);
        else raddr_q <= raddr_q + 1'b1;
        if (cnt_q != win_q) cnt_q <= cnt_q + 1'b1;
      end
      spws_pkg::ST_MUL_DC: begin
        dvd_q <= DW'(sum_q * vref_mv_i);
        dvs_q <= DW'(win_q * fs);
      end
      spws_pkg::ST_DIV_DC: begin
        if (div_done) dc_q <= (quo > DW'(spws_pkg::MvSat)) ? spws_pkg::MvSat : quo[12:0];
      end
      spws_pkg::ST_MUL_VPP: begin
        dvd_q <= DW'((max_q - min_q) * vref_mv_i);
        dvs_q <= DW'(fs);
      end
      spws_pkg::ST_DIV_VPP: begin
        if (div_done) begin
          vpp_q <= (quo > DW'(spws_pkg::MvSat)) ? spws_pkg::MvSat : quo[12:0];
          dvd_q <= DW'(100000000);
          dvs_q <= DW'(period_q);
          freq_q <= '0;
        end
      end
      spws_pkg::ST_DIV_FREQ: begin
        if (div_done) freq_q <= quo[26:0];
      end
      default: ;
    endcase
    if (rd_valid_q) begin
      sum_q <= sum_q + SumW'(rdata);
      if (rdata > max_q) max_q <= rdata;
      if (rdata < min_q) min_q <= rdata;
    end
  end
endmodule
`default_nettype wire

[rtl/sine_period_and_window_stats.sv]
`default_nettype none
// An accepted sample is registered in the queue before the back end pops it and writes
// it to the ring, so samples stream at one per cycle while the back end is idle. A
// capture holds the back end through a scan of the window and three divisions (two
// when the period is unknown), and then until its result is taken.
// After reset the ring is cleared, one entry a cycle, while no transaction is taken
// into the back end; configuration returns to defaults.
module sine_period_and_window_stats #(
  parameter int unsigned RingDepth  = spws_pkg::RingDepthDef,
  parameter int unsigned SampleBits = spws_pkg::SampleBitsDef,
  parameter int unsigned MinWindow  = spws_pkg::MinWindowDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            req_type_i,
  input  wire logic [11:0]                     sample_code_i,
  input  wire logic [15:0]                     capture_time_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [spws_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [spws_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 period_known_o,
  output logic [31:0]                          period_us_o,
  output logic [26:0]                          frequency_centihz_o,
  output logic [10:0]                          window_len_o,
  output logic [12:0]                          dc_offset_mv_o,
  output logic [12:0]                          vpp_mv_o,
  output logic [11:0]                          amplitude_mv_o
);
  logic [19:0] rate_q;
  logic [15:0] tick_q, fs_q;
  logic [12:0] vref_q;

  // Configuration registers written directly by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 20'd10000;
      tick_q <= 16'd100;
      vref_q <= 13'd3300;
      fs_q   <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (spws_pkg::cfg_idx_e'(cfg_index_i))
        spws_pkg::CFG_SAMPLE_RATE: rate_q <= cfg_data_i;
        spws_pkg::CFG_TICK_US:     tick_q <= cfg_data_i[15:0];
        spws_pkg::CFG_VREF:        vref_q <= cfg_data_i[12:0];
        spws_pkg::CFG_FULL_SCALE:  fs_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  spws_pkg::item_t in_item, q_item;
  logic            q_valid, q_pop;

  // Samples and captures share one data field in the queue.
  assign in_item.is_capture = req_type_i;
  assign in_item.data = req_type_i ? capture_time_i : {4'd0, sample_code_i};

  spws_front #(.QDepth(4)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  spws_back #(
    .RingDepth(RingDepth), .SampleBits(SampleBits), .MinWindow(MinWindow)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_pop_o             (q_pop),
    .q_item_i            (q_item),
    .sample_rate_hz_i    (rate_q),
    .tick_us_i           (tick_q),
    .vref_mv_i           (vref_q),
    .full_scale_code_i   (fs_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .period_known_o      (period_known_o),
    .period_us_o         (period_us_o),
    .frequency_centihz_o (frequency_centihz_o),
    .window_len_o        (window_len_o),
    .dc_offset_mv_o      (dc_offset_mv_o),
    .vpp_mv_o            (vpp_mv_o),
    .amplitude_mv_o      (amplitude_mv_o)
  );
endmodule
`default_nettype wire

[sim/tb_sine_period_and_window_stats.sv]
`timescale 1ns / 100ps
module tb_sine_period_and_window_stats;

  localparam int unsigned Depth = spws_pkg::RingDepthDef;
  localparam int unsigned MinWin = spws_pkg::MinWindowDef;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // Stimulus side of the block.
  logic in_valid_i = 1'b0;
  logic req_type_i = 1'b0;
  logic [11:0] sample_code_i = '0;
  logic [15:0] capture_time_i = '0;
  logic cfg_we_i = 1'b0;
  logic [spws_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [spws_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_stall_o;

  // Result side of the block.
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic period_known_o;
  logic [31:0] period_us_o;
  logic [26:0] frequency_centihz_o;
  logic [10:0] window_len_o;
  logic [12:0] dc_offset_mv_o;
  logic [12:0] vpp_mv_o;
  logic [11:0] amplitude_mv_o;

  sine_period_and_window_stats i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .sample_code_i,
    .capture_time_i, .cfg_we_i, .cfg_index_i, .cfg_data_i, .out_valid_o,
    .out_stall_i, .period_known_o, .period_us_o, .frequency_centihz_o,
    .window_len_o, .dc_offset_mv_o, .vpp_mv_o, .amplitude_mv_o
  );

  // One measurement report, as the block should present it.
  typedef struct packed {
    logic        known;
    logic [31:0] period;
    logic [26:0] freq;
    logic [10:0] win;
    logic [12:0] dc;
    logic [12:0] vpp;
    logic [11:0] amp;
  } report_t;

  report_t pending_reports[$];
  int unsigned error_count = 0;

  // Shadow copy of the block's state and registers.
  logic [11:0] ring_shadow[Depth];
  logic [9:0] wr_ptr;
  logic [15:0] last_stamp;
  logic first_edge_pending;
  logic [31:0] period_hold;
  logic [19:0] rate_reg;
  logic [15:0] tick_reg;
  logic [12:0] vref_reg;
  logic [15:0] fs_reg;

  function automatic logic [63:0] clamp_mv(logic [63:0] v);
    return (v > 64'(spws_pkg::MvSat)) ? 64'(spws_pkg::MvSat) : v;
  endfunction

  // Updates the shadow state for one transaction and queues the report a
  // capture produces. Samples produce no report.
  task automatic predict_meter(logic kind, logic [11:0] code, logic [15:0] stamp);
    logic [15:0] delta;
    logic [63:0] win, sum, dc, vpp, fs, freq;
    logic [11:0] hi, lo, v;
    int unsigned base;
    report_t r;
    if (kind == spws_pkg::REQ_SAMPLE) begin
      ring_shadow[wr_ptr] = code;
      wr_ptr = wr_ptr + 10'd1;
      return;
    end
    if (first_edge_pending) begin
      first_edge_pending = 1'b0;
    end else begin
      delta = stamp - last_stamp;
      if (delta != 0) period_hold = 32'(64'(delta) * 64'(tick_reg));
    end
    last_stamp = stamp;
    win = (64'(period_hold) * 64'(rate_reg)) / 64'd2000000;
    if (win < MinWin) win = MinWin;
    if (win > Depth) win = Depth;
    base = (int'(wr_ptr) + Depth - int'(win)) % Depth;
    sum = 0;
    hi = '0;
    lo = '1;
    for (int unsigned i = 0; i < win; i++) begin
      v = ring_shadow[(base + i) % Depth];
      sum += v;
      if (v > hi) hi = v;
      if (v < lo) lo = v;
    end
    fs = (fs_reg == 0) ? 64'd1 : 64'(fs_reg);
    dc = clamp_mv((sum * vref_reg) / (win * fs));
    vpp = clamp_mv((64'(hi - lo) * vref_reg) / fs);
    freq = (period_hold != 0) ? 64'd100000000 / 64'(period_hold) : 64'd0;
    r.known = (period_hold != 0);
    r.period = period_hold;
    r.freq = freq[26:0];
    r.win = win[10:0];
    r.dc = dc[12:0];
    r.vpp = vpp[12:0];
    r.amp = 12'(vpp / 2);
    pending_reports.push_back(r);
  endtask

  // Sender: bursts of random length with random gaps between them. Valid stays
  // high between the transactions of a burst and drops only for a gap.
  int unsigned burst_left = 0;

  task automatic send_item(logic kind, logic [11:0] code, logic [15:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    sample_code_i <= code;
    capture_time_i <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_meter(kind, code, stamp);
  endtask

  // Stops sending, waits until every queued report has come out, then lets the
  // back end finish any trailing sample work before the caller touches registers.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (Depth + 16) @(posedge clk_i);
  endtask

  task automatic write_reg(spws_pkg::cfg_idx_e idx, logic [spws_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      spws_pkg::CFG_SAMPLE_RATE: rate_reg = val[19:0];
      spws_pkg::CFG_TICK_US:     tick_reg = val[15:0];
      spws_pkg::CFG_VREF:        vref_reg = val[12:0];
      default:                   fs_reg = val[15:0];
    endcase
  endtask

  task automatic set_regs(logic [19:0] rate, logic [15:0] tick, logic [12:0] vref,
                          logic [15:0] fs);
    drain_reports();
    write_reg(spws_pkg::CFG_SAMPLE_RATE, rate);
    write_reg(spws_pkg::CFG_TICK_US, 20'(tick));
    write_reg(spws_pkg::CFG_VREF, 20'(vref));
    write_reg(spws_pkg::CFG_FULL_SCALE, 20'(fs));
    cfg_we_i <= 1'b0;
  endtask

  // Receiver stall pattern: alternates between quiet stretches and stretches
  // of random stalling.
  initial begin
    forever begin
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(20, 300)) begin
        @(posedge clk_i);
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Result checker: compares each accepted transaction with the oldest report.
  always @(posedge clk_i) begin
    report_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        e = pending_reports.pop_front();
        if (period_known_o !== e.known) begin
          $error("period_known exp %0d got %0d", e.known, period_known_o);
          error_count++;
        end
        if (period_us_o !== e.period) begin
          $error("period_us exp %0d got %0d", e.period, period_us_o);
          error_count++;
        end
        if (frequency_centihz_o !== e.freq) begin
          $error("frequency_centihz exp %0d got %0d", e.freq, frequency_centihz_o);
          error_count++;
        end
        if (window_len_o !== e.win) begin
          $error("window_len exp %0d got %0d", e.win, window_len_o);
          error_count++;
        end
        if (dc_offset_mv_o !== e.dc) begin
          $error("dc_offset_mv exp %0d got %0d", e.dc, dc_offset_mv_o);
          error_count++;
        end
        if (vpp_mv_o !== e.vpp) begin
          $error("vpp_mv exp %0d got %0d", e.vpp, vpp_mv_o);
          error_count++;
        end
        if (amplitude_mv_o !== e.amp) begin
          $error("amplitude_mv exp %0d got %0d", e.amp, amplitude_mv_o);
          error_count++;
        end
      end
    end
  end

  // Directed checks: edge handling, zero delta, wrap, and extreme codes.
  task automatic test_edges();
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'hFFFF);    // first edge, period unknown
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'hFFFF);    // zero delta keeps unknown
    send_item(spws_pkg::REQ_SAMPLE, 12'hFFF, 16'h0);
    send_item(spws_pkg::REQ_SAMPLE, 12'h000, 16'hFFFF);
    send_item(spws_pkg::REQ_SAMPLE, 12'hA5A, 16'h0);
    send_item(spws_pkg::REQ_CAPTURE, 12'hFFF, 16'h0009);  // wrapped difference
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'h0009);    // zero delta keeps period
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'h0008);    // near full-range delta
    for (int i = 0; i < 12; i++) begin
      send_item(spws_pkg::REQ_SAMPLE, i[0] ? 12'hFFF : 12'h000, 16'h0);
    end
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'h0010);
  endtask

  // Register extremes, including zero tick and zero full scale.
  task automatic test_register_extremes();
    set_regs(20'd1000000, 16'd65535, 13'd5000, 16'd1);
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'h0100);
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'h0100 + 16'd1);
    set_regs(20'd1, 16'd1, 13'd1, 16'd65535);
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'h0100 + 16'd2);
    set_regs(20'hFFFFF, 16'd0, 13'h1FFF, 16'd0);
    send_item(spws_pkg::REQ_CAPTURE, 12'h0, 16'h0200);  // zero tick: period unknown
  endtask

  // Random traffic: mostly samples, with captures spaced over a plausible
  // signal period so the window reaches deep into the ring.
  task automatic test_random(int unsigned n);
    logic [15:0] stamp;
    stamp = 16'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        stamp = stamp + 16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 40));
        send_item(spws_pkg::REQ_CAPTURE, 12'($urandom), stamp);
      end else begin
        send_item(spws_pkg::REQ_SAMPLE, 12'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    wr_ptr = '0;
    last_stamp = '0;
    first_edge_pending = 1'b1;
    period_hold = '0;
    rate_reg = 20'd10000;
    tick_reg = 16'd100;
    vref_reg = 13'd3300;
    fs_reg = 16'd4096;
    foreach (ring_shadow[i]) ring_shadow[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_register_extremes();
    set_regs(20'd10000, 16'd100, 13'd3300, 16'd4096);
    test_random(450);
    set_regs(20'd200000, 16'd10, 13'd5000, 16'd4096);
    test_random(450);
    set_regs(20'($urandom_range(1, 1000000)), 16'($urandom_range(1, 65535)),
             13'($urandom_range(1, 5000)), 16'($urandom_range(1, 65535)));
    test_random(400);
    drain_reports();
    repeat (Depth + 300) @(posedge clk_i);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
